// File: design/bcm_pkg.sv
// Package for the binary cross morphology core: frame limits, field widths,
// register indexes, input kinds, modes and pixel values. No dependencies.
package bcm_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int DIM_W = 12;
	localparam int PIX_W = 8;

	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	localparam logic MODE_DILATE = 1'b0;
	localparam logic MODE_ERODE  = 1'b1;

	localparam logic [PIX_W-1:0] PIX_SET   = 8'd255;
	localparam logic [PIX_W-1:0] PIX_CLEAR = 8'd0;

	localparam logic [DIM_W-1:0] DIM_MIN   = 12'd2;
	localparam logic [DIM_W-1:0] WIDTH_MAX = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

endpackage

// File: design/binary_cross_morphology_core.sv
// Binary 3x3 cross dilation/erosion over a raster pixel stream, two line stores.
// Depends on bcm_pkg.
//
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_ready    kind, pixel_in
// out      source     out_valid / out_ready  pixel_out, out_row, out_col, frame_end
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// One transaction per clock on in and out, unless out_ready holds back a result.
// Stage s1 holds the line store read data; the result register follows it.
// in_ready drops only when s1 holds a result and the result register is held by out_ready.
// Results lag one row; flush transactions drain the last row of the frame.
// Reset clears position, pending count and valid flags and sets the configuration to defaults; no clearing pass.
module binary_cross_morphology_core
	import bcm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             kind,
	input  logic [PIX_W-1:0] pixel_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] pixel_out,
	output logic [ROW_W-1:0] out_row,
	output logic [COL_W-1:0] out_col,
	output logic             frame_end,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	logic             mode_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	logic [COL_W-1:0] input_col_q;
	logic [ROW_W-1:0] input_row_q;
	logic [DIM_W-1:0] pending_q;
	logic             win_q;

	logic middle_mem [MAX_WIDTH];
	logic upper_mem [MAX_WIDTH];

	logic             valid_s1;
	logic             emit_s1;
	logic             upd_s1;
	logic             pixel_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             has_up_s1;
	logic             has_down_s1;
	logic             down_s1;
	logic             has_left_s1;
	logic             has_right_s1;
	logic             frame_end_s1;
	logic             ctr_s1;
	logic             rgt_s1;
	logic             up_s1;

	logic             out_valid_q;
	logic [PIX_W-1:0] pix_out_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             frame_end_q;

	logic [DIM_W-1:0] eff_w;
	logic [DIM_W-1:0] eff_h;
	logic [DIM_W-1:0] pcol;
	logic [DIM_W-1:0] prow;
	logic [DIM_W-1:0] ncol;
	logic [DIM_W-1:0] nrow;
	logic [DIM_W-1:0] npend;
	logic [DIM_W-1:0] pend_c;
	logic [DIM_W-1:0] fcol;
	logic [DIM_W-1:0] cur_col;
	logic [COL_W-1:0] rd_col;
	logic [COL_W-1:0] rd_col_r;
	logic             flush_act;
	logic             emit_c;
	logic [ROW_W-1:0] row_c;
	logic             accept;
	logic             adv;
	logic             res_dil;
	logic             res_ero;
	logic             res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_DILATE;
			width_q  <= WIDTH_MAX;
			height_q <= HEIGHT_MAX;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_data[0];
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame size clamped to the supported range
	always_comb begin
		eff_w = width_q;
		if (width_q < DIM_MIN)
			eff_w = DIM_MIN;
		else if (width_q > WIDTH_MAX)
			eff_w = WIDTH_MAX;
		eff_h = height_q;
		if (height_q < DIM_MIN)
			eff_h = DIM_MIN;
		else if (height_q > HEIGHT_MAX)
			eff_h = HEIGHT_MAX;
	end

	// position of this transaction and the state it leaves behind
	always_comb begin
		pcol = {{(DIM_W-COL_W){1'b0}}, input_col_q};
		prow = {{(DIM_W-ROW_W){1'b0}}, input_row_q};
		if (pcol >= eff_w) begin
			pcol = '0;
			prow = prow + 1'b1;
		end
		if (prow >= eff_h)
			prow = '0;

		ncol  = pcol + 1'b1;
		nrow  = prow;
		npend = '0;
		if (ncol >= eff_w) begin
			ncol = '0;
			nrow = prow + 1'b1;
			if (nrow >= eff_h) begin
				nrow  = '0;
				npend = eff_w;
			end
		end

		pend_c    = (pending_q > eff_w) ? eff_w : pending_q;
		fcol      = eff_w - pend_c;
		flush_act = (pending_q != '0);

		cur_col  = (kind == KIND_FLUSH) ? fcol : pcol;
		rd_col   = cur_col[COL_W-1:0];
		rd_col_r = rd_col + 1'b1;

		if (kind == KIND_FLUSH) begin
			emit_c = flush_act;
			row_c  = ROW_W'(eff_h - 1'b1);
		end else begin
			emit_c = (prow != '0);
			row_c  = ROW_W'(prow - 1'b1);
		end
	end

	assign adv      = valid_s1 && (!emit_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_col_q <= '0;
			input_row_q <= '0;
			pending_q   <= '0;
		end else if (accept) begin
			if (kind == KIND_PIXEL) begin
				input_col_q <= ncol[COL_W-1:0];
				input_row_q <= nrow[ROW_W-1:0];
				pending_q   <= npend;
			end else if (flush_act) begin
				pending_q <= pend_c - 1'b1;
			end
		end
	end

	// middle line: reads at col and col+1, written with the new pixel
	always_ff @(posedge clk) begin
		if (accept) begin
			ctr_s1 <= middle_mem[rd_col];
			rgt_s1 <= middle_mem[rd_col_r];
			if (kind == KIND_PIXEL)
				middle_mem[rd_col] <= (pixel_in != '0);
		end
	end

	// upper line: written with the old center once a pixel transaction in s1 retires
	always_ff @(posedge clk) begin
		if (accept)
			up_s1 <= upper_mem[rd_col];
		if (adv && pixel_s1)
			upper_mem[col_s1] <= ctr_s1;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1      <= emit_c;
			upd_s1       <= (kind == KIND_PIXEL) || flush_act;
			pixel_s1     <= (kind == KIND_PIXEL);
			col_s1       <= rd_col;
			row_s1       <= row_c;
			has_up_s1    <= (kind == KIND_FLUSH) || (prow >= DIM_W'(2));
			has_down_s1  <= (kind == KIND_PIXEL);
			down_s1      <= (pixel_in != '0);
			has_left_s1  <= (cur_col != '0);
			has_right_s1 <= ((cur_col + 1'b1) < eff_w);
			frame_end_s1 <= (kind == KIND_FLUSH) && ((cur_col + 1'b1) == eff_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			win_q    <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv && upd_s1)
				win_q <= ctr_s1;
		end
	end

	always_comb begin
		res_dil = ctr_s1 || (has_up_s1 && up_s1) || (has_down_s1 && down_s1) ||
			(has_left_s1 && win_q) || (has_right_s1 && rgt_s1);
		res_ero = ctr_s1 && (!has_up_s1 || up_s1) && (!has_down_s1 || down_s1) &&
			(!has_left_s1 || win_q) && (!has_right_s1 || rgt_s1);
		res = (mode_q == MODE_ERODE) ? res_ero : res_dil;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv && emit_s1)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && emit_s1) begin
			pix_out_q   <= res ? PIX_SET : PIX_CLEAR;
			out_row_q   <= row_s1;
			out_col_q   <= col_s1;
			frame_end_q <= frame_end_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pix_out_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign frame_end = frame_end_q;

	a_pix_binary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_out == PIX_SET || pixel_out == PIX_CLEAR))
		else $error("result pixel not binary");

	a_frame_end_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> ({1'b0, out_col} + 1'b1) == eff_w)
		else $error("frame end off the last column");

	a_s1_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |-> out_valid_q && !out_ready && emit_s1)
		else $error("s1 held without a blocked result");

	a_noop_flush: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == KIND_FLUSH && pending_q == '0 |=> valid_s1 && !emit_s1 && !upd_s1)
		else $error("empty flush produced work");

endmodule
